/* src/pcr_pkg.sv */
`default_nettype none
package pcr_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int KEY_BITS      = 16;
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    localparam int USED_BITS     = $clog2(TABLE_ENTRIES + 1);
    localparam int RANK_BITS     = 7;
    localparam int CNT_BITS      = 16;
    localparam int FIFO_DEPTH    = 2;

    localparam logic CMD_COUNT  = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [KEY_BITS-1:0] key;
    } pcr_word_t;

    typedef enum logic [1:0] {
        ST_COUNT,
        ST_SCAN,
        ST_EMIT
    } pcr_state_t;
endpackage
`default_nettype wire

/* src/participation_count_ranking.sv */
`default_nettype none
// channel | valid   | ready   | payload
// input   | s_valid | s_ready | s_cmd, s_student_key
// result  | m_valid | m_ready | m_rank, m_key_out, m_occurrences, m_last,
//         |         |         | m_empty_res, m_overflowed
// a count word is handled in the back end by a parallel key match per entry
// a finish word with n entries ranks them one at a time: per rank, a
// scan over every entry finds the largest unemitted count, then one emit
// a 2-word queue lets the input keep taking words while the back end stalls
// aresetn is synchronous: clears the queue, entry count and overflow flag
module participation_count_ranking (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_cmd,
    input  wire logic [15:0] s_student_key,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [6:0]       m_rank,
    output logic [15:0]      m_key_out,
    output logic [15:0]      m_occurrences,
    output logic             m_last,
    output logic             m_empty_res,
    output logic             m_overflowed
);
    import pcr_pkg::*;

    // queue between front and back
    logic      q_valid, q_ready;
    pcr_word_t q_word;

    pcr_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_cmd, .s_student_key,
        .q_valid, .q_ready, .q_word
    );

    pcr_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_word,
        .m_valid, .m_ready, .m_rank, .m_key_out, .m_occurrences,
        .m_last, .m_empty_res, .m_overflowed
    );

    // empty result always is rank zero and last
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_res |-> m_last && m_rank == 7'd0)
        else $error("empty result malformed");

    // a real result never carries rank zero
    a_rank_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_empty_res |-> m_rank != 7'd0)
        else $error("ranked result with zero rank");

    // stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rank) && $stable(m_key_out))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

/* src/pcr_front.sv */
`default_nettype none
// input skid queue: decouples the input handshake from the counting engine
module pcr_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_cmd,
    input  wire logic [15:0]       s_student_key,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output pcr_pkg::pcr_word_t     q_word
);
    import pcr_pkg::*;

    pcr_word_t mem_reg [FIFO_DEPTH];
    logic      wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push, pop;

    assign s_ready = (cnt_reg != 2'(FIFO_DEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_word  = mem_reg[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= '{cmd: s_cmd, key: s_student_key[KEY_BITS-1:0]};
        end
    end
endmodule
`default_nettype wire

/* src/pcr_back.sv */
`default_nettype none
// counting table and ranking by repeated max scan
module pcr_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    output logic                      q_ready,
    input  wire pcr_pkg::pcr_word_t   q_word,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [6:0]                m_rank,
    output logic [15:0]               m_key_out,
    output logic [15:0]               m_occurrences,
    output logic                      m_last,
    output logic                      m_empty_res,
    output logic                      m_overflowed
);
    import pcr_pkg::*;

    logic [KEY_BITS-1:0] key_reg [TABLE_ENTRIES];
    logic [CNT_BITS-1:0] cnt_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] done_reg, done_next;
    logic [USED_BITS-1:0] used_reg, used_next;
    logic drop_reg, drop_next;
    pcr_state_t state_reg, state_next;
    logic [IDX_BITS-1:0] scan_reg, scan_next;
    logic [IDX_BITS-1:0] best_reg, best_next;
    logic best_ok_reg, best_ok_next;
    logic [RANK_BITS-1:0] rank_reg, rank_next;

    logic m_valid_reg, m_valid_next;
    logic [6:0] o_rank_reg, o_rank_next;
    logic [15:0] o_key_reg, o_key_next, o_cnt_reg, o_cnt_next;
    logic o_last_reg, o_last_next, o_empty_reg, o_empty_next, o_ovf_reg, o_ovf_next;

    logic any_hit;
    logic [IDX_BITS-1:0] hit_idx;
    logic take;
    logic out_free;

    always_comb begin
        any_hit = 1'b0;
        hit_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (USED_BITS'(i) < used_reg && key_reg[i] == q_word.key) begin
                any_hit = 1'b1;
                hit_idx = IDX_BITS'(i);
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = (state_reg == ST_COUNT) &&
                      (q_word.cmd == CMD_COUNT || out_free);
    assign take     = q_valid && q_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_COUNT: if (take && q_word.cmd == CMD_FINISH && used_reg != '0) begin
                state_next = ST_SCAN;
            end
            ST_SCAN: if (USED_BITS'(scan_reg) == used_reg - 1'b1) begin
                state_next = ST_EMIT;
            end
            ST_EMIT: if (out_free) begin
                state_next = (USED_BITS'(rank_reg) + 1'b1 == used_reg) ? ST_COUNT : ST_SCAN;
            end
            default: state_next = ST_COUNT;
        endcase
    end

    always_comb begin
        used_next    = used_reg;
        drop_next    = drop_reg;
        done_next    = done_reg;
        scan_next    = scan_reg;
        best_next    = best_reg;
        best_ok_next = best_ok_reg;
        rank_next    = rank_reg;
        m_valid_next = m_valid_reg && !m_ready;
        o_rank_next  = o_rank_reg;
        o_key_next   = o_key_reg;
        o_cnt_next   = o_cnt_reg;
        o_last_next  = o_last_reg;
        o_empty_next = o_empty_reg;
        o_ovf_next   = o_ovf_reg;
        case (state_reg)
            ST_COUNT: if (take) begin
                if (q_word.cmd == CMD_COUNT) begin
                    if (!any_hit) begin
                        if (used_reg != USED_BITS'(TABLE_ENTRIES)) begin
                            used_next = used_reg + 1'b1;
                        end else begin
                            drop_next = 1'b1;
                        end
                    end
                end else if (used_reg == '0) begin
                    m_valid_next = 1'b1;
                    o_rank_next  = '0;
                    o_key_next   = '0;
                    o_cnt_next   = '0;
                    o_last_next  = 1'b1;
                    o_empty_next = 1'b1;
                    o_ovf_next   = drop_reg;
                    drop_next    = 1'b0;
                end else begin
                    done_next    = '0;
                    scan_next    = '0;
                    best_ok_next = 1'b0;
                    rank_next    = '0;
                end
            end
            ST_SCAN: begin
                // strict greater keeps first appearance on ties
                if (!done_reg[scan_reg] &&
                    (!best_ok_reg || cnt_reg[scan_reg] > cnt_reg[best_reg])) begin
                    best_next    = scan_reg;
                    best_ok_next = 1'b1;
                end
                scan_next = scan_reg + 1'b1;
            end
            ST_EMIT: if (out_free) begin
                m_valid_next = 1'b1;
                rank_next    = rank_reg + 1'b1;
                o_rank_next  = rank_reg + 1'b1;
                o_key_next   = 16'(key_reg[best_reg]);
                o_cnt_next   = cnt_reg[best_reg];
                o_last_next  = (USED_BITS'(rank_reg) + 1'b1 == used_reg);
                o_empty_next = 1'b0;
                o_ovf_next   = drop_reg;
                done_next[best_reg] = 1'b1;
                scan_next    = '0;
                best_ok_next = 1'b0;
                if (USED_BITS'(rank_reg) + 1'b1 == used_reg) begin
                    used_next = '0;
                    drop_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_COUNT;
            used_reg    <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        done_reg    <= done_next;
        scan_reg    <= scan_next;
        best_reg    <= best_next;
        best_ok_reg <= best_ok_next;
        rank_reg    <= rank_next;
        o_rank_reg  <= o_rank_next;
        o_key_reg   <= o_key_next;
        o_cnt_reg   <= o_cnt_next;
        o_last_reg  <= o_last_next;
        o_empty_reg <= o_empty_next;
        o_ovf_reg   <= o_ovf_next;
        if (state_reg == ST_COUNT && take && q_word.cmd == CMD_COUNT) begin
            if (any_hit) begin
                if (cnt_reg[hit_idx] != '1) begin
                    cnt_reg[hit_idx] <= cnt_reg[hit_idx] + 1'b1;
                end
            end else if (used_reg != USED_BITS'(TABLE_ENTRIES)) begin
                key_reg[used_reg[IDX_BITS-1:0]] <= q_word.key;
                cnt_reg[used_reg[IDX_BITS-1:0]] <= CNT_BITS'(1);
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_rank        = o_rank_reg;
    assign m_key_out     = o_key_reg;
    assign m_occurrences = o_cnt_reg;
    assign m_last        = o_last_reg;
    assign m_empty_res   = o_empty_reg;
    assign m_overflowed  = o_ovf_reg;
endmodule
`default_nettype wire

/* verif/participation_count_ranking_checker.sv */
`timescale 1ns / 1ps
module participation_count_ranking_checker
    import pcr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_cmd,
    input  wire logic [15:0] s_student_key,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [6:0]  m_rank,
    input  wire logic [15:0] m_key_out,
    input  wire logic [15:0] m_occurrences,
    input  wire logic        m_last,
    input  wire logic        m_empty_res,
    input  wire logic        m_overflowed,
    output int               fail_count,
    output int               pending_ranks,
    output int               ranks_seen
);
    typedef struct packed {
        logic [6:0]  rank;
        logic [15:0] key;
        logic [15:0] occ;
        logic        last;
        logic        empty;
        logic        ovf;
    } rank_row_t;

    logic [KEY_BITS-1:0] tally_keys [TABLE_ENTRIES];
    logic [CNT_BITS-1:0] tally_cnts [TABLE_ENTRIES];
    int                  tally_used;
    logic                tally_dropped;
    rank_row_t           ranking_q [$];

    assign pending_ranks = ranking_q.size();

    task automatic tally_key(input logic [15:0] key);
        for (int i = 0; i < tally_used; i++) begin
            if (tally_keys[i] == key) begin
                if (tally_cnts[i] != 16'hFFFF) tally_cnts[i]++;
                return;
            end
        end
        if (tally_used < TABLE_ENTRIES) begin
            tally_keys[tally_used] = key;
            tally_cnts[tally_used] = 1;
            tally_used++;
        end else begin
            tally_dropped = 1'b1;
        end
    endtask

    task automatic rank_tally();
        logic [15:0] k [TABLE_ENTRIES];
        logic [15:0] c [TABLE_ENTRIES];
        logic [15:0] hk, hc;
        int j;
        rank_row_t row;
        if (tally_used == 0) begin
            row = '{rank: 0, key: 0, occ: 0, last: 1, empty: 1, ovf: tally_dropped};
            ranking_q.push_back(row);
        end else begin
            k = tally_keys;
            c = tally_cnts;
            // stable insertion sort, descending
            for (int i = 1; i < tally_used; i++) begin
                hk = k[i];
                hc = c[i];
                j = i;
                while (j > 0 && c[j-1] < hc) begin
                    k[j] = k[j-1];
                    c[j] = c[j-1];
                    j--;
                end
                k[j] = hk;
                c[j] = hc;
            end
            for (int i = 0; i < tally_used; i++) begin
                row = '{rank: 7'(i + 1), key: k[i], occ: c[i],
                        last: (i + 1 == tally_used), empty: 1'b0, ovf: tally_dropped};
                ranking_q.push_back(row);
            end
        end
        tally_used = 0;
        tally_dropped = 1'b0;
    endtask

    always @(posedge aclk) begin
        rank_row_t want;
        if (!aresetn) begin
            tally_used    = 0;
            tally_dropped = 1'b0;
            fail_count    <= 0;
            ranks_seen    <= 0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_cmd == CMD_COUNT) tally_key(s_student_key);
                else rank_tally();
            end
            if (m_valid && m_ready) begin
                ranks_seen <= ranks_seen + 1;
                if (ranking_q.size() == 0) begin
                    $error("unexpected result word rank=%0d key=%0h", m_rank, m_key_out);
                    fail_count <= fail_count + 1;
                end else begin
                    want = ranking_q.pop_front();
                    if ({m_rank, m_key_out, m_occurrences, m_last, m_empty_res,
                         m_overflowed} != want) begin
                        fail_count <= fail_count + 1;
                        if (m_rank != want.rank)
                            $error("rank: expected %0d got %0d", want.rank, m_rank);
                        if (m_key_out != want.key)
                            $error("key_out: expected %0h got %0h", want.key, m_key_out);
                        if (m_occurrences != want.occ)
                            $error("occurrences: expected %0d got %0d",
                                   want.occ, m_occurrences);
                        if (m_last != want.last)
                            $error("last: expected %0b got %0b", want.last, m_last);
                        if (m_empty_res != want.empty)
                            $error("empty_res: expected %0b got %0b",
                                   want.empty, m_empty_res);
                        if (m_overflowed != want.ovf)
                            $error("overflowed: expected %0b got %0b",
                                   want.ovf, m_overflowed);
                    end
                end
            end
        end
    end
endmodule

/* verif/participation_count_ranking_test.sv */
`timescale 1ns / 1ps
module participation_count_ranking_test;
    import pcr_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_cmd = CMD_COUNT;
    logic [15:0] s_student_key = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [6:0]  m_rank;
    logic [15:0] m_key_out, m_occurrences;
    logic        m_last, m_empty_res, m_overflowed;
    int          fail_count, pending_ranks, ranks_seen;

    // idling odds in percent, changed per phase
    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;
    bit          recv_hold = 1'b0;
    int          words_sent = 0;

    participation_count_ranking uut (.*);

    participation_count_ranking_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // reset held low at the start only
    initial begin
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // receiver: random stalls, or a long hold when requested
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // offer one word and wait for acceptance; valid stays up for a word that
    // follows at once, and drops only for a gap or when the sender stops
    task automatic send_word(input logic cmd, input logic [15:0] key);
        if ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_gap_pct) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_student_key <= key;
        @(posedge aclk iff s_ready);
        words_sent++;
    endtask

    // stop sending and wait until every expected word is back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_ranks != 0) @(posedge aclk);
    endtask

    // a well-formed session: some records over a small key pool, then finish
    task automatic session(input int records, input int pool);
        logic [15:0] base;
        base = 16'($urandom);
        for (int i = 0; i < records; i++)
            send_word(CMD_COUNT, base ^ 16'($urandom_range(pool - 1)));
        send_word(CMD_FINISH, 16'($urandom));
    endtask

    initial begin
        int rounds;
        wait (aresetn === 1'b1);
        @(posedge aclk);

        // directed: empty finish, field extremes, equal-count tie order
        send_word(CMD_FINISH, 16'hFFFF);
        send_word(CMD_COUNT, 16'h0000);
        send_word(CMD_COUNT, 16'hFFFF);
        send_word(CMD_COUNT, 16'hFFFF);
        send_word(CMD_COUNT, 16'h5555);
        send_word(CMD_COUNT, 16'hAAAA);
        send_word(CMD_COUNT, 16'h0000);
        send_word(CMD_FINISH, 16'h0000);
        drain();

        // full table: 64 keys, then new keys dropped while known keys still count
        for (int i = 0; i < TABLE_ENTRIES; i++) send_word(CMD_COUNT, 16'(i * 3));
        send_word(CMD_COUNT, 16'hBEEF);
        send_word(CMD_COUNT, 16'(9));
        send_word(CMD_FINISH, 16'h0);
        // dropped flag cleared by finish, so this empty run reports no overflow
        send_word(CMD_FINISH, 16'h0);
        drain();

        // random phases: none, sender idle, receiver stalls, both
        for (int ph = 0; ph < 4; ph++) begin
            send_gap_pct   = (ph == 1) ? 63 : (ph == 3) ? 33 : 0;
            recv_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 33 : 0;
            rounds = 0;
            while (rounds < 4) begin
                if ($urandom_range(9) == 0) send_word(CMD_FINISH, 16'($urandom));
                else session($urandom_range(1, 12), $urandom_range(1, 8));
                rounds++;
            end
            // sender pauses until every expected word is back
            drain();
        end

        // long receiver hold while the sender keeps offering: input must stall
        fork
            begin
                recv_hold = 1'b1;
                repeat (300) @(posedge aclk);
                recv_hold = 1'b0;
            end
            begin
                session(6, 3);
                session(4, 2);
                session(3, 3);
                drain();
            end
        join
        drain();
        repeat (20 * TABLE_ENTRIES * TABLE_ENTRIES) begin
            @(posedge aclk);
            if (m_valid) break;
        end
        repeat (50) @(posedge aclk);

        $display("covered %0d input words and %0d result words: empty, full, overflow,",
                 words_sent, ranks_seen);
        $display("tied and random sessions under sender gaps and receiver stalls");
        if (fail_count == 0 && pending_ranks == 0) begin
            $display("** participation_count_ranking: PASSED **");
        end else begin
            $display("** participation_count_ranking: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("** participation_count_ranking: FAILED **");
        $finish;
    end
endmodule

/* filelist.f */
src/pcr_pkg.sv
src/pcr_front.sv
src/pcr_back.sv
src/participation_count_ranking.sv
verif/participation_count_ranking_checker.sv
verif/participation_count_ranking_test.sv
